@@ rtl/aifd_pkg.sv @@
// aifd_pkg: shared types and codes of the arm instruction field decoder
`timescale 1ns / 1ps
`default_nettype none

package aifd_pkg;

  localparam int unsigned InWidth   = 64;
  localparam int unsigned OutWidth  = 80;
  localparam int unsigned RecWidth  = 77;

  typedef enum logic [3:0] {
    CLS_BRANCH   = 4'd0,
    CLS_SWI      = 4'd1,
    CLS_BX       = 4'd2,
    CLS_BLX      = 4'd3,
    CLS_BLOCK    = 4'd4,
    CLS_SINGLE   = 4'd5,
    CLS_STATUS   = 4'd6,
    CLS_MULTIPLY = 4'd7,
    CLS_DATAPROC = 4'd8,
    CLS_UNDEF    = 4'd9
  } insn_class_e;

  typedef enum logic [1:0] {
    OPK_IMM     = 2'd0,
    OPK_REG     = 2'd1,
    OPK_REG_IMM = 2'd2,
    OPK_REG_REG = 2'd3
  } operand_kind_e;

  // control flag bit positions
  localparam int unsigned FlLink  = 0;
  localparam int unsigned FlLoad  = 1;
  localparam int unsigned FlWb    = 2;
  localparam int unsigned FlUp    = 3;
  localparam int unsigned FlPre   = 4;
  localparam int unsigned FlByte  = 5;
  localparam int unsigned FlSetf  = 6;
  localparam int unsigned FlSpsr  = 7;

  // instruction group codes, bits 27..25
  localparam logic [2:0] GrpSingleImm = 3'd2;
  localparam logic [2:0] GrpSingleReg = 3'd3;
  localparam logic [2:0] GrpBlock     = 3'd4;
  localparam logic [2:0] GrpBranch    = 3'd5;
  localparam logic [2:0] GrpSwi       = 3'd7;

  // pattern masks and matches
  localparam logic [31:0] BxMask      = 32'h0FF0_00F0;
  localparam logic [31:0] BxMatch     = 32'h0120_0010;
  localparam logic [31:0] BlxMatch    = 32'h0120_0030;
  localparam logic [31:0] StatGrpMask = 32'h0C00_0000;
  localparam logic [31:0] StatMask    = 32'h0190_0000;
  localparam logic [31:0] StatMatch   = 32'h0100_0000;
  localparam logic [31:0] MulMask     = 32'h0F00_00F0;
  localparam logic [31:0] MulMatch    = 32'h0000_0090;

  // data-processing opcodes that drop Rn or Rd
  localparam logic [3:0] OpTst = 4'd8;
  localparam logic [3:0] OpCmn = 4'd11;
  localparam logic [3:0] OpMov = 4'd13;
  localparam logic [3:0] OpMvn = 4'd15;

  // status move sub-opcode, mrs is zero
  localparam logic [3:0] SubMsr = 4'd1;

  typedef struct packed {
    logic [31:0]   decoded_value;
    logic [4:0]    shift_amount;
    logic [1:0]    shift_kind;
    operand_kind_e operand_kind;
    logic [3:0]    shift_reg;
    logic [3:0]    operand_reg;
    logic [3:0]    base_reg;
    logic [3:0]    dest_reg;
    logic [7:0]    control_flags;
    logic [3:0]    sub_opcode;
    logic [3:0]    condition;
    insn_class_e   insn_class;
  } dec_t;

endpackage

`default_nettype wire

@@ rtl/arm_instruction_field_decoder_unit.sv @@
// arm_instruction_field_decoder_unit: decodes one arm instruction per beat into a field record
`timescale 1ns / 1ps
`default_nettype none

// Takes one 32-bit ARM instruction and its fetch address per input beat and returns
// exactly one decoded record per beat, in order. The beat is captured in an input
// register, decoded by one level of combinational logic (class priority, field
// selection, immediate rotation and the branch-target adder) and held in an output
// register. A beat accepted into the input register is decoded from it and moves on to the
// output register when that register is empty or its result is being taken, so a stalled
// output holds it in the input register; one instruction is accepted every cycle while the
// output side keeps taking results.
// The input stage refills in the same cycle its contents move to the output register,
// so backpressure reaches s_axis_tready_o only when both stages are full.
module arm_instruction_field_decoder_unit
  import aifd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // fetch_address[31:0], instruction_word[63:32]
  input  wire logic [InWidth-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // insn_class[3:0], condition[7:4], sub_opcode[11:8], control_flags[19:12],
  // dest_reg[23:20], base_reg[27:24], operand_reg[31:28], shift_reg[35:32],
  // operand_kind[37:36], shift_kind[39:38], shift_amount[44:40],
  // decoded_value[76:45], zero[79:77]
  output logic [OutWidth-1:0]      m_axis_tdata_o
);

  logic        in_valid_q, in_valid_d;
  logic [31:0] in_addr_q;
  logic [31:0] in_word_q;
  logic        out_valid_q, out_valid_d;
  dec_t        out_q;
  dec_t        dec;
  logic        out_load;
  logic        in_load;

  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_load;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_q);
  assign out_valid_d = out_load ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_addr_q <= s_axis_tdata_i[31:0];
      in_word_q <= s_axis_tdata_i[63:32];
    end
    if (out_load && in_valid_q) begin
      out_q <= dec;
    end
  end

  // ---------------------------------------------------------------- decode
  logic [2:0]    grp;
  logic [31:0]   rot_imm;
  logic [63:0]   rot_wide;
  logic [4:0]    rot_amt;
  logic [31:0]   br_off;
  logic [31:0]   br_target;
  logic [3:0]    xfer_flags;
  operand_kind_e sr_kind;
  logic [3:0]    dp_op;

  assign grp      = in_word_q[27:25];
  assign rot_amt  = {in_word_q[11:8], 1'b0};
  assign rot_wide = {24'd0, in_word_q[7:0], 24'd0, in_word_q[7:0]} >> rot_amt;
  assign rot_imm  = rot_wide[31:0];
  assign br_off   = {{6{in_word_q[23]}}, in_word_q[23:0], 2'b00};
  assign br_target = in_addr_q + 32'd8 + br_off;
  // load, writeback, up, pre
  assign xfer_flags = {in_word_q[24], in_word_q[23], in_word_q[21], in_word_q[20]};
  assign sr_kind  = (in_word_q[11:7] == 5'd0 && in_word_q[6:5] == 2'd0) ? OPK_REG
                                                                         : OPK_REG_IMM;
  assign dp_op    = in_word_q[24:21];

  always_comb begin
    dec            = '0;
    dec.insn_class = CLS_UNDEF;
    dec.condition  = in_word_q[31:28];

    if (grp == GrpBranch) begin
      dec.insn_class            = CLS_BRANCH;
      dec.control_flags[FlLink] = in_word_q[24];
      dec.decoded_value         = br_target;
    end else if (grp == GrpSwi) begin
      dec.insn_class    = CLS_SWI;
      dec.decoded_value = {8'd0, in_word_q[23:0]};
    end else if ((in_word_q & BxMask) == BxMatch) begin
      dec.insn_class  = CLS_BX;
      dec.operand_reg = in_word_q[3:0];
    end else if ((in_word_q & BxMask) == BlxMatch) begin
      dec.insn_class  = CLS_BLX;
      dec.operand_reg = in_word_q[3:0];
    end else if (grp == GrpBlock) begin
      dec.insn_class                  = CLS_BLOCK;
      dec.sub_opcode                  = {2'b00, in_word_q[24], in_word_q[23]};
      dec.control_flags[FlPre:FlLoad] = xfer_flags;
      dec.base_reg                    = in_word_q[19:16];
      dec.decoded_value               = {16'd0, in_word_q[15:0]};
    end else if (grp == GrpSingleImm || grp == GrpSingleReg) begin
      dec.insn_class                  = CLS_SINGLE;
      dec.control_flags[FlPre:FlLoad] = xfer_flags;
      dec.control_flags[FlByte]       = in_word_q[22];
      dec.dest_reg                    = in_word_q[15:12];
      dec.base_reg                    = in_word_q[19:16];
      if (in_word_q[25]) begin
        dec.operand_reg  = in_word_q[3:0];
        dec.shift_kind   = in_word_q[6:5];
        dec.shift_amount = in_word_q[11:7];
        dec.operand_kind = sr_kind;
      end else begin
        dec.operand_kind  = OPK_IMM;
        dec.decoded_value = {20'd0, in_word_q[11:0]};
      end
    end else if ((in_word_q & StatGrpMask) == 32'd0 && (in_word_q & StatMask) == StatMatch) begin
      dec.insn_class            = CLS_STATUS;
      dec.control_flags[FlSpsr] = in_word_q[22];
      if (in_word_q[21]) begin
        dec.sub_opcode = SubMsr;
      end else begin
        dec.dest_reg   = in_word_q[15:12];
      end
    end else if ((in_word_q & MulMask) == MulMatch) begin
      dec.insn_class            = CLS_MULTIPLY;
      dec.sub_opcode            = {1'b0, in_word_q[23:21]};
      dec.control_flags[FlSetf] = in_word_q[20];
      dec.dest_reg              = in_word_q[19:16];
      dec.base_reg              = in_word_q[15:12];
      dec.operand_reg           = in_word_q[3:0];
      dec.shift_reg             = in_word_q[11:8];
    end else if (!grp[2] && !grp[1]) begin
      dec.insn_class            = CLS_DATAPROC;
      dec.sub_opcode            = dp_op;
      dec.control_flags[FlSetf] = in_word_q[20];
      if (dp_op != OpMov && dp_op != OpMvn) begin
        dec.base_reg = in_word_q[19:16];
      end
      if (dp_op < OpTst || dp_op > OpCmn) begin
        dec.dest_reg = in_word_q[15:12];
      end
    end

    // operand 2 for data processing and msr
    if ((dec.insn_class == CLS_DATAPROC) ||
        (dec.insn_class == CLS_STATUS && in_word_q[21])) begin
      if (in_word_q[25]) begin
        dec.operand_kind  = OPK_IMM;
        dec.decoded_value = rot_imm;
      end else begin
        dec.operand_reg = in_word_q[3:0];
        dec.shift_kind  = in_word_q[6:5];
        if (in_word_q[4]) begin
          dec.operand_kind = OPK_REG_REG;
          dec.shift_reg    = in_word_q[11:8];
        end else begin
          dec.shift_amount = in_word_q[11:7];
          dec.operand_kind = sr_kind;
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutWidth - RecWidth){1'b0}}, out_q};

  // ------------------------------------------------------------ assertions
  a_undef_only_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[3:0] == CLS_UNDEF) |-> (m_axis_tdata_o[79:8] == '0))
    else $error("undefined instruction carries fields");

  a_regreg_no_amt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[37:36] == OPK_REG_REG) |-> (m_axis_tdata_o[44:40] == '0))
    else $error("register-shifted operand with a shift amount");

  a_branch_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[3:0] == CLS_BRANCH) |-> (m_axis_tdata_o[19:13] == '0))
    else $error("branch with flags other than link");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while both stages are full");

endmodule

`default_nettype wire

@@ sim/arm_instruction_field_decoder_unit_tb.sv @@
// self-checking testbench of the arm instruction field decoder with random stream stalls
`timescale 1ns / 1ps

module arm_instruction_field_decoder_unit_tb;
  import aifd_pkg::*;

  typedef struct {
    logic [63:0] beat;
    bit          drain_first;
  } fetch_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [InWidth-1:0]  s_data = '0;
  logic                m_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutWidth-1:0] m_axis_tdata_o;

  fetch_t      fetch_q[$];
  dec_t        decoded_q[$];
  int unsigned err_cnt = 0;
  int unsigned results_seen = 0;
  logic        in_fire = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm = 0;
  int unsigned rx_long_left = 0;
  bit          long_done = 1'b0;
  dec_t        want_rec;
  dec_t        got_rec;

  arm_instruction_field_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("arm_instruction_field_decoder_unit_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------- decode predictor

  function automatic logic [7:0] xfer_flags(input logic [31:0] w);
    logic [7:0] f;
    f = '0;
    f[FlLoad] = w[20];
    f[FlWb]   = w[21];
    f[FlUp]   = w[23];
    f[FlPre]  = w[24];
    return f;
  endfunction

  function automatic dec_t with_shifted_reg(input dec_t d, input logic [31:0] w,
                                            input bit reg_shift_ok);
    d.operand_reg = w[3:0];
    d.shift_kind  = w[6:5];
    if (reg_shift_ok && w[4]) begin
      d.operand_kind = OPK_REG_REG;
      d.shift_reg    = w[11:8];
    end else begin
      d.shift_amount = w[11:7];
      // lsl #0 is a plain register
      d.operand_kind = (w[11:5] == 7'd0) ? OPK_REG : OPK_REG_IMM;
    end
    return d;
  endfunction

  function automatic dec_t with_operand2(input dec_t d, input logic [31:0] w);
    logic [63:0] rot;
    if (w[25]) begin
      rot = {24'h0, w[7:0], 24'h0, w[7:0]} >> {w[11:8], 1'b0};
      d.operand_kind  = OPK_IMM;
      d.decoded_value = rot[31:0];
    end else begin
      d = with_shifted_reg(d, w, 1'b1);
    end
    return d;
  endfunction

  function automatic dec_t decode_insn(input logic [31:0] addr, input logic [31:0] w);
    dec_t        d;
    logic [2:0]  grp;
    logic [3:0]  op;
    logic [31:0] off;
    d = '0;
    grp = w[27:25];
    d.condition = w[31:28];
    if (grp == GrpBranch) begin
      d.insn_class = CLS_BRANCH;
      d.control_flags[FlLink] = w[24];
      off = {{6{w[23]}}, w[23:0], 2'b00};
      d.decoded_value = addr + 32'd8 + off;
    end else if (grp == GrpSwi) begin
      d.insn_class = CLS_SWI;
      d.decoded_value = {8'h0, w[23:0]};
    end else if ((w & BxMask) == BxMatch) begin
      d.insn_class = CLS_BX;
      d.operand_reg = w[3:0];
    end else if ((w & BxMask) == BlxMatch) begin
      d.insn_class = CLS_BLX;
      d.operand_reg = w[3:0];
    end else if (grp == GrpBlock) begin
      d.insn_class = CLS_BLOCK;
      d.sub_opcode = {2'b00, w[24], w[23]};
      d.control_flags = xfer_flags(w);
      d.base_reg = w[19:16];
      d.decoded_value = {16'h0, w[15:0]};
    end else if (grp == GrpSingleImm || grp == GrpSingleReg) begin
      d.insn_class = CLS_SINGLE;
      d.control_flags = xfer_flags(w);
      d.control_flags[FlByte] = w[22];
      d.dest_reg = w[15:12];
      d.base_reg = w[19:16];
      if (w[25]) begin
        d = with_shifted_reg(d, w, 1'b0);
      end else begin
        d.operand_kind = OPK_IMM;
        d.decoded_value = {20'h0, w[11:0]};
      end
    end else if ((w & StatGrpMask) == 32'h0 && (w & StatMask) == StatMatch) begin
      d.insn_class = CLS_STATUS;
      d.control_flags[FlSpsr] = w[22];
      if (w[21]) begin
        d.sub_opcode = SubMsr;
        d = with_operand2(d, w);
      end else begin
        d.dest_reg = w[15:12];
      end
    end else if ((w & MulMask) == MulMatch) begin
      d.insn_class = CLS_MULTIPLY;
      d.sub_opcode = {1'b0, w[23:21]};
      d.control_flags[FlSetf] = w[20];
      d.dest_reg = w[19:16];
      d.base_reg = w[15:12];
      d.operand_reg = w[3:0];
      d.shift_reg = w[11:8];
    end else if (grp[2:1] == 2'b00) begin
      op = w[24:21];
      d.insn_class = CLS_DATAPROC;
      d.sub_opcode = op;
      d.control_flags[FlSetf] = w[20];
      if (op != OpMov && op != OpMvn) d.base_reg = w[19:16];
      if (op < OpTst || op > OpCmn) d.dest_reg = w[15:12];
      d = with_operand2(d, w);
    end else begin
      d.insn_class = CLS_UNDEF;
    end
    return d;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    else if (r < 95) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // mostly words forced into one class, random elsewhere
  function automatic logic [31:0] rand_word();
    logic [31:0] r;
    logic [31:0] mask;
    logic [31:0] match;
    r = $urandom();
    mask = 32'h0E00_0000;
    match = 32'h0;
    case ($urandom_range(0, 13))
      0, 1: mask = 32'h0;
      2: match = {4'h0, GrpBranch, 25'h0};
      3: match = {4'h0, GrpSwi, 25'h0};
      4: begin mask = BxMask; match = BxMatch; end
      5: begin mask = BxMask; match = BlxMatch; end
      6: match = {4'h0, GrpBlock, 25'h0};
      7: begin mask = 32'h0C00_0000; match = 32'h0400_0000; end
      8: begin mask = 32'h0E00_0FE0; match = {4'h0, GrpSingleReg, 25'h0}; end
      9: begin mask = StatGrpMask | StatMask; match = StatMatch; end
      10: begin mask = MulMask; match = MulMatch; end
      11: mask = 32'h0C00_0000;
      12: mask = 32'h0E00_0FF0;
      default: match = 32'h0C00_0000;
    endcase
    return (r & ~mask) | match;
  endfunction

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 19))
      0: return 32'h0;
      1: return 32'hFFFF_FFFC;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFC;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_fetch(input logic [31:0] addr, input logic [31:0] w, input bit drain);
    fetch_t f;
    f.beat = {w, addr};
    f.drain_first = drain;
    fetch_q.push_back(f);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------- input driver

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || in_fire) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          s_valid <= 1'b0;
        end else if (fetch_q.size() != 0 &&
                     !(fetch_q[0].drain_first && decoded_q.size() != 0)) begin
          s_data <= fetch_q[0].beat;
          s_valid <= 1'b1;
          void'(fetch_q.pop_front());
          if (tx_calm != 0) tx_calm <= tx_calm - 1;
          else if ($urandom_range(0, 99) == 0) tx_calm <= $urandom_range(40, 120);
          // keep offering while the receiver holds off so the pipe fills
          if (tx_calm != 0 || rx_long_left != 0 || $urandom_range(0, 99) >= 30) tx_gap <= 0;
          else tx_gap <= idle_len();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output ready

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_long_left != 0) begin
        rx_long_left <= rx_long_left - 1;
        m_ready <= 1'b0;
      end else if (!long_done && results_seen >= 600) begin
        long_done <= 1'b1;
        rx_long_left <= 150;
        m_ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if (rx_calm != 0) rx_calm <= rx_calm - 1;
        else if ($urandom_range(0, 99) == 0) rx_calm <= $urandom_range(40, 120);
        else if ($urandom_range(0, 99) < 20) rx_stall <= idle_len();
      end
    end
  end

  // ---------------------------------------------------------------- beat monitor

  always @(posedge clk_i) begin
    in_fire <= s_valid && s_axis_tready_o;
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        decoded_q.push_back(decode_insn(s_data[31:0], s_data[63:32]));
      end
      if (m_axis_tvalid_o && m_ready) begin
        results_seen <= results_seen + 1;
        if (decoded_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat, expected none, got %h", $time, m_axis_tdata_o);
        end else begin
          want_rec = decoded_q.pop_front();
          got_rec = dec_t'(m_axis_tdata_o[RecWidth-1:0]);
          check_field("insn_class", 32'(want_rec.insn_class), 32'(got_rec.insn_class));
          check_field("condition", 32'(want_rec.condition), 32'(got_rec.condition));
          check_field("sub_opcode", 32'(want_rec.sub_opcode), 32'(got_rec.sub_opcode));
          check_field("control_flags", 32'(want_rec.control_flags),
                      32'(got_rec.control_flags));
          check_field("dest_reg", 32'(want_rec.dest_reg), 32'(got_rec.dest_reg));
          check_field("base_reg", 32'(want_rec.base_reg), 32'(got_rec.base_reg));
          check_field("operand_reg", 32'(want_rec.operand_reg), 32'(got_rec.operand_reg));
          check_field("shift_reg", 32'(want_rec.shift_reg), 32'(got_rec.shift_reg));
          check_field("operand_kind", 32'(want_rec.operand_kind),
                      32'(got_rec.operand_kind));
          check_field("shift_kind", 32'(want_rec.shift_kind), 32'(got_rec.shift_kind));
          check_field("shift_amount", 32'(want_rec.shift_amount),
                      32'(got_rec.shift_amount));
          check_field("decoded_value", want_rec.decoded_value, got_rec.decoded_value);
          check_field("pad", 32'h0, 32'(m_axis_tdata_o[OutWidth-1:RecWidth]));
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // branches: max forward, max backward with link, wrap past the top
    push_fetch(32'h0000_1000, 32'hEA7F_FFFF, 1'b0);
    push_fetch(32'h0000_0000, 32'h0B80_0000, 1'b0);
    push_fetch(32'hFFFF_FFFC, 32'hEAFF_FFFE, 1'b0);
    // swi, all ones and all zero number
    push_fetch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_fetch(32'h0000_0004, 32'hEF00_0000, 1'b0);
    push_fetch(32'h0000_0008, 32'hE12F_FF1E, 1'b0);
    push_fetch(32'h0000_000C, 32'hE12F_FF33, 1'b0);
    // block transfers, including bit 22 set
    push_fetch(32'h0000_0010, 32'hE9BD_8FF0, 1'b0);
    push_fetch(32'h0000_0014, 32'hE800_0001, 1'b0);
    push_fetch(32'h0000_0018, 32'hE8FF_FFFF, 1'b0);
    // single transfers: immediate, register lsl #0, shifted with bit 4 set
    push_fetch(32'h0000_001C, 32'hE5F1_2FFF, 1'b0);
    push_fetch(32'h0000_0020, 32'hE781_2003, 1'b0);
    push_fetch(32'h0000_0024, 32'hE791_2FF3, 1'b0);
    // status moves: mrs spsr, msr immediate, msr register, swap
    push_fetch(32'h0000_0028, 32'hE14F_0000, 1'b0);
    push_fetch(32'h0000_002C, 32'hE32F_F4FF, 1'b0);
    push_fetch(32'h0000_0030, 32'hE129_F00E, 1'b0);
    push_fetch(32'h0000_0034, 32'hE101_2093, 1'b0);
    // multiplies
    push_fetch(32'h0000_0038, 32'hE010_0291, 1'b0);
    push_fetch(32'h0000_003C, 32'hE033_4392, 1'b0);
    push_fetch(32'h0000_0040, 32'hE0FF_FF9F, 1'b0);
    // data processing: movs rotated, mvn reg by reg, tst, cmn, add, and zero
    push_fetch(32'h0000_0044, 32'hE3BF_0CFF, 1'b0);
    push_fetch(32'h0000_0048, 32'hE1EF_1312, 1'b0);
    push_fetch(32'h0000_004C, 32'hE11F_1A4F, 1'b0);
    push_fetch(32'h0000_0050, 32'hE37F_F0FF, 1'b0);
    push_fetch(32'h0000_0054, 32'hE081_2003, 1'b0);
    push_fetch(32'h0000_0058, 32'h0000_0000, 1'b0);
    // coprocessor space falls to undefined
    push_fetch(32'h0000_005C, 32'hFDFF_FFFF, 1'b0);
    for (int i = 0; i < 1850; i++) begin
      // the first random beat and one mid-run wait until the pipe has drained
      push_fetch(rand_addr(), rand_word(), (i == 0) || (i == 900));
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (fetch_q.size() != 0 || s_valid || decoded_q.size() != 0);
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("arm_instruction_field_decoder_unit_tb passed");
    end else begin
      $display("arm_instruction_field_decoder_unit_tb failed");
    end
    $finish;
  end

endmodule
